// ===== hw/rtl/gbn_pkg.sv =====
// Shared types and constants for the go-back-n sender window.
// No dependencies; imported by every module of the block.
package gbn_pkg;

	localparam int SEQ_W = 33;
	localparam int OFF_W = 33;
	localparam int LEN_W = 32;
	localparam int PAY_W = 11;
	localparam int WSZ_W = 6;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [WSZ_W-1:0] WINDOW_SIZE_RST = 6'd4;
	localparam logic [LEN_W-1:0] TIMEOUT_RST = 32'd1000;
	localparam logic [LEN_W-1:0] FILE_LENGTH_RST = 32'd0;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_ACK   = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_TIMEOUT     = 2'd1,
		REG_FILE_LENGTH = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	// one queued send or status word between front and back
	typedef struct packed {
		logic             send_valid;
		logic [LEN_W-1:0] seq;
		logic [OFF_W-1:0] off;
		logic             retx;
		logic             done;
		logic             last;
	} word_t;

endpackage

// ===== hw/rtl/gbn_front.sv =====
// Front end: accepts items, updates the window state and issues one word per cycle
// while the queue is not full. Depends on gbn_pkg.
module gbn_front #(
	parameter int CHUNK_BYTES = 1024,
	parameter int WINDOW_MAX = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 operation,
	input  logic [gbn_pkg::LEN_W-1:0]  ack_number,
	input  logic                       checksum_ok,
	input  logic [gbn_pkg::WSZ_W-1:0]  window_size,
	input  logic [gbn_pkg::LEN_W-1:0]  timeout_ticks,
	input  logic [gbn_pkg::LEN_W-1:0]  file_length,
	output gbn_pkg::word_t             word,
	output logic                       word_push,
	input  logic                       queue_full
);
	import gbn_pkg::*;

	localparam int W_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = SEQ_W + 1;
	localparam int CMP_W = W_W + WSZ_W;
	localparam logic [OFF_W-1:0] CHUNK_OFF = OFF_W'(CHUNK_BYTES);
	localparam logic [W_W-1:0] WMAX = W_W'(WINDOW_MAX);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_RESEND,
		ST_STATUS
	} state_t;

	state_t            state_q;
	logic [SEQ_W-1:0]  base_q;
	logic [SEQ_W-1:0]  next_q;
	logic [OFF_W-1:0]  off_next_q;
	logic [LEN_W-1:0]  elapsed_q;
	logic              active_q;
	logic              fin_q;
	logic [SEQ_W-1:0]  cur_q;
	logic [OFF_W-1:0]  cur_off_q;

	logic [W_W-1:0]    w_eff;
	logic [OFF_W-1:0]  len_ext;
	logic [SUM_W-1:0]  lim;
	logic [SUM_W-1:0]  next_ext;
	logic              can_send;
	logic              can_more;
	logic [OFF_W-1:0]  off_adv;
	logic [SEQ_W-1:0]  ack_ext;
	logic              ack_good;
	logic [SEQ_W-1:0]  base_new;
	logic              pc_hit;
	logic [LEN_W-1:0]  el_inc;
	logic [W_W-1:0]    span;
	logic [OFF_W-1:0]  rs_off;
	logic              busy;
	op_t               op;

	always_comb begin
		if (window_size == '0) begin
			w_eff = W_W'(1);
		end else if (CMP_W'(window_size) > CMP_W'(WINDOW_MAX)) begin
			w_eff = WMAX;
		end else begin
			w_eff = W_W'(window_size);
		end
	end

	assign op       = op_t'(operation);
	assign len_ext  = OFF_W'(file_length);
	assign lim      = SUM_W'(base_q) + SUM_W'(w_eff);
	assign next_ext = SUM_W'(next_q);
	assign off_adv  = off_next_q + CHUNK_OFF;
	assign can_send = (off_next_q < len_ext) && (next_ext < lim);
	assign can_more = (off_adv < len_ext) && ((next_ext + SUM_W'(1)) < lim);
	assign ack_ext  = SEQ_W'(ack_number);
	assign ack_good = checksum_ok && (ack_ext >= base_q) && (ack_ext < next_q);
	assign base_new = ack_good ? (ack_ext + SEQ_W'(1)) : base_q;
	assign pc_hit   = (off_next_q >= len_ext) &&
		((next_q == SEQ_W'(1)) || ((off_next_q - CHUNK_OFF) < len_ext));
	assign el_inc   = (&elapsed_q) ? elapsed_q : (elapsed_q + LEN_W'(1));
	assign span     = W_W'(next_q - base_q);
	assign rs_off   = off_next_q - (OFF_W'(span) * CHUNK_OFF);
	assign busy     = (state_q != ST_IDLE);
	assign full     = busy;
	assign word_push = busy;

	always_comb begin
		word = '0;
		word.done = fin_q;
		word.last = 1'b1;
		case (state_q)
			ST_FILL: begin
				if (can_send) begin
					word.send_valid = 1'b1;
					word.seq = next_q[LEN_W-1:0];
					word.off = off_next_q;
					word.last = !can_more;
				end
			end
			ST_RESEND: begin
				word.send_valid = 1'b1;
				word.seq = cur_q[LEN_W-1:0];
				word.off = cur_off_q;
				word.retx = 1'b1;
				word.last = ((cur_q + SEQ_W'(1)) == next_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			base_q     <= SEQ_W'(1);
			next_q     <= SEQ_W'(1);
			off_next_q <= '0;
			elapsed_q  <= '0;
			active_q   <= 1'b0;
			fin_q      <= 1'b0;
			cur_q      <= '0;
			cur_off_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						state_q <= ST_STATUS;
						case (op)
							OP_START: begin
								base_q     <= SEQ_W'(1);
								next_q     <= SEQ_W'(1);
								off_next_q <= '0;
								elapsed_q  <= '0;
								active_q   <= 1'b1;
								fin_q      <= (file_length == '0);
								if (file_length != '0) begin
									state_q <= ST_FILL;
								end
							end
							OP_TICK: begin
								if (active_q && !fin_q) begin
									if (el_inc > timeout_ticks) begin
										elapsed_q <= '0;
										if (next_q != base_q) begin
											cur_q     <= base_q;
											cur_off_q <= rs_off;
											state_q   <= ST_RESEND;
										end
									end else begin
										elapsed_q <= el_inc;
									end
								end
							end
							OP_ACK: begin
								if (active_q && !fin_q) begin
									base_q <= base_new;
									if ((base_new == next_q) && pc_hit) begin
										fin_q <= 1'b1;
									end else begin
										state_q <= ST_FILL;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					if (!queue_full) begin
						if (can_send) begin
							next_q     <= next_q + SEQ_W'(1);
							off_next_q <= off_adv;
							elapsed_q  <= '0;
						end
						if (!can_send || !can_more) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RESEND: begin
					if (!queue_full) begin
						cur_q     <= cur_q + SEQ_W'(1);
						cur_off_q <= cur_off_q + CHUNK_OFF;
						if ((cur_q + SEQ_W'(1)) == next_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STATUS: begin
					if (!queue_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/gbn_fifo.sv =====
// Short word queue between the front end and the result stage.
// Depends on gbn_pkg for the word type.
module gbn_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  gbn_pkg::word_t  wr_word,
	output logic            full,
	input  logic            rd_en,
	output gbn_pkg::word_t  rd_word,
	output logic            empty
);
	import gbn_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	word_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : (wr_ptr_q + AW'(1));
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : (rd_ptr_q + AW'(1));
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/gbn_back.sv =====
// Back end: sizes each send's payload and holds the result word for the consumer.
// Depends on gbn_pkg.
module gbn_back #(
	parameter int CHUNK_BYTES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gbn_pkg::word_t             q_word,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  logic [gbn_pkg::LEN_W-1:0]  file_length,
	output logic                       empty,
	input  logic                       pop,
	output logic                       send_valid,
	output logic [gbn_pkg::LEN_W-1:0]  sequence_number,
	output logic [gbn_pkg::LEN_W-1:0]  byte_offset,
	output logic [gbn_pkg::PAY_W-1:0]  payload_bytes,
	output logic                       is_retransmit,
	output logic                       transfer_done,
	output logic                       last
);
	import gbn_pkg::*;

	localparam logic [OFF_W-1:0] CHUNK_OFF = OFF_W'(CHUNK_BYTES);

	logic              valid_q;
	logic              sv_q;
	logic [LEN_W-1:0]  seq_q;
	logic [LEN_W-1:0]  off_q;
	logic [PAY_W-1:0]  pay_q;
	logic              retx_q;
	logic              done_q;
	logic              last_q;
	logic [OFF_W-1:0]  len_ext;
	logic [OFF_W-1:0]  rest;
	logic [OFF_W-1:0]  pay_full;
	logic              load;

	assign len_ext = OFF_W'(file_length);
	assign rest    = len_ext - q_word.off;
	assign load    = !q_empty && (!valid_q || pop);
	assign q_pop   = load;

	always_comb begin
		pay_full = '0;
		if (q_word.send_valid && (len_ext > q_word.off)) begin
			pay_full = (rest > CHUNK_OFF) ? CHUNK_OFF : rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sv_q   <= q_word.send_valid;
			seq_q  <= q_word.seq;
			off_q  <= q_word.off[LEN_W-1:0];
			pay_q  <= pay_full[PAY_W-1:0];
			retx_q <= q_word.retx;
			done_q <= q_word.done;
			last_q <= q_word.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	assign empty           = !valid_q;
	assign send_valid      = sv_q;
	assign sequence_number = seq_q;
	assign byte_offset     = off_q;
	assign payload_bytes   = pay_q;
	assign is_retransmit   = retx_q;
	assign transfer_done   = done_q;
	assign last            = last_q;

endmodule

// ===== hw/rtl/go_back_n_sender_window.sv =====
// Top level of the go-back-n sender window: config registers, front end, queue, back end.
// Depends on gbn_pkg, gbn_front, gbn_fifo and gbn_back.
//
//   channel   direction  handshake          word
//   input     in         push / full        operation, ack_number, checksum_ok
//   result    out        empty / pop        send_valid .. last
//   config    in         cfg_valid / ready  cfg_index, cfg_data
//
// An item is taken when push meets a low full; then, while the queue is not full, the
// front end queues one word per cycle: one per send (up to the window size) or a single
// status word. full stays high until the last word of the item is queued.
// A full queue stalls the front end; the back end registers each queued word as a result.
// Reset clears the window state and loads the register defaults; cfg_ready is always high.
module go_back_n_sender_window #(
	parameter int CHUNK_BYTES = 1024,
	parameter int WINDOW_MAX = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 operation,
	input  logic [gbn_pkg::LEN_W-1:0]  ack_number,
	input  logic                       checksum_ok,
	output logic                       empty,
	input  logic                       pop,
	output logic                       send_valid,
	output logic [gbn_pkg::LEN_W-1:0]  sequence_number,
	output logic [gbn_pkg::LEN_W-1:0]  byte_offset,
	output logic [gbn_pkg::PAY_W-1:0]  payload_bytes,
	output logic                       is_retransmit,
	output logic                       transfer_done,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [gbn_pkg::LEN_W-1:0]  cfg_data
);
	import gbn_pkg::*;

	logic [WSZ_W-1:0]  window_size_q;
	logic [LEN_W-1:0]  timeout_q;
	logic [LEN_W-1:0]  file_length_q;
	word_t             f_word;
	logic              f_push;
	logic              q_full;
	word_t             q_word;
	logic              q_empty;
	logic              q_pop;
	reg_idx_t          idx;

	assign cfg_ready = 1'b1;
	assign idx = reg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
			timeout_q     <= TIMEOUT_RST;
			file_length_q <= FILE_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (idx)
				REG_WINDOW_SIZE: window_size_q <= cfg_data[WSZ_W-1:0];
				REG_TIMEOUT:     timeout_q <= cfg_data;
				REG_FILE_LENGTH: file_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gbn_front #(
		.CHUNK_BYTES(CHUNK_BYTES),
		.WINDOW_MAX(WINDOW_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.ack_number(ack_number),
		.checksum_ok(checksum_ok),
		.window_size(window_size_q),
		.timeout_ticks(timeout_q),
		.file_length(file_length_q),
		.word(f_word),
		.word_push(f_push),
		.queue_full(q_full)
	);

	gbn_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(f_push),
		.wr_word(f_word),
		.full(q_full),
		.rd_en(q_pop),
		.rd_word(q_word),
		.empty(q_empty)
	);

	gbn_back #(
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_word(q_word),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.file_length(file_length_q),
		.empty(empty),
		.pop(pop),
		.send_valid(send_valid),
		.sequence_number(sequence_number),
		.byte_offset(byte_offset),
		.payload_bytes(payload_bytes),
		.is_retransmit(is_retransmit),
		.transfer_done(transfer_done),
		.last(last)
	);

	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front end did not go busy after taking an item");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !send_valid) |-> last)
		else $error("status word not marked last");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !send_valid) |->
		(sequence_number == '0 && payload_bytes == '0 && !is_retransmit))
		else $error("status word carries send fields");

	a_resend_has_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_retransmit) |-> send_valid)
		else $error("resend without a send");

endmodule
